[hdl/ftp_reply_code_parser_assert.svh]
// Assertion macros used by the checker of the FTP reply-code parser.
`ifndef FTP_REPLY_CODE_PARSER_ASSERT_SVH
`define FTP_REPLY_CODE_PARSER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define FRCP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("frcp assertion failed");

// The consequent must hold at the clock edge after the antecedent.
`define FRCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frcp assertion failed");

`endif

[hdl/frcp_pkg.sv]
// Package of the FTP reply-code parser: constants, event type and helpers.
package frcp_pkg;

    localparam int MAX_LINE    = 4096;
    localparam int LINE_POS_W  = $clog2(MAX_LINE);
    localparam int CODE_DIGITS = 3;
    localparam int HEAD_DEPTH  = CODE_DIGITS + 1;
    localparam int CODE_W      = 10;

    // A line is forced to end once it holds MAX_LINE-1 bytes.
    localparam logic [LINE_POS_W-1:0] LINE_LAST = LINE_POS_W'(MAX_LINE - 2);

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_CLOSED = 1'b1;

    // One classified line end or stream end, passed from front to back.
    typedef struct packed {
        logic              is_end;
        logic              judged;
        logic              digits_ok;
        logic [CODE_W-1:0] value;
        logic              is_dash;
        logic              is_space;
    } t_evt;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [CODE_W-1:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return CODE_W'(d[3:0]);
    endfunction

endpackage

[hdl/frcp_ifs.sv]
// Handshake interfaces for the byte input and the reply output channels.
interface frcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       stream_end;

    modport source (output valid, output rx_byte, output stream_end, input ready);
    modport sink (input valid, input rx_byte, input stream_end, output ready);
endinterface

interface frcp_out_if;
    logic                      valid;
    logic                      ready;
    logic [frcp_pkg::CODE_W-1:0] reply_code;
    logic                      status;

    modport source (output valid, output reply_code, output status, input ready);
    modport sink (input valid, input reply_code, input status, output ready);
endinterface

[hdl/frcp_front.sv]
// Front part: splits bytes into lines and classifies each line end.
module frcp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    frcp_in_if.sink              i_rx,
    input  logic                 i_q_full,
    output logic                 o_push,
    output frcp_pkg::t_evt       o_evt
);

    logic [frcp_pkg::LINE_POS_W-1:0] r_pos;
    logic [7:0]                      r_head [frcp_pkg::HEAD_DEPTH];
    logic [7:0]                      n_head [frcp_pkg::HEAD_DEPTH];
    logic [7:0]                      v_head [frcp_pkg::HEAD_DEPTH];
    logic                            accept;
    logic                            line_done;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;

    always_comb begin
        for (int i = 0; i < frcp_pkg::HEAD_DEPTH; i++) begin
            n_head[i] = (r_pos == frcp_pkg::LINE_POS_W'(i)) ? i_rx.rx_byte : r_head[i];
        end
        line_done = !i_rx.stream_end &&
                    ((i_rx.rx_byte == frcp_pkg::CH_LF) || (r_pos >= frcp_pkg::LINE_LAST));
        // A stream end carries no byte, so it judges the head as it stands.
        for (int i = 0; i < frcp_pkg::HEAD_DEPTH; i++) begin
            v_head[i] = i_rx.stream_end ? r_head[i] : n_head[i];
        end
        o_evt.is_end    = i_rx.stream_end;
        o_evt.judged    = !i_rx.stream_end || (r_pos != '0);
        o_evt.digits_ok = frcp_pkg::is_dec(v_head[0]) && frcp_pkg::is_dec(v_head[1]) &&
                          frcp_pkg::is_dec(v_head[2]);
        o_evt.value     = frcp_pkg::CODE_W'(frcp_pkg::digit_val(v_head[0]) * 10'd100)
                        + frcp_pkg::CODE_W'(frcp_pkg::digit_val(v_head[1]) * 10'd10)
                        + frcp_pkg::digit_val(v_head[2]);
        o_evt.is_dash   = v_head[frcp_pkg::CODE_DIGITS] == frcp_pkg::CH_DASH;
        o_evt.is_space  = v_head[frcp_pkg::CODE_DIGITS] == frcp_pkg::CH_SPACE;
        o_push          = accept && (i_rx.stream_end || line_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int i = 0; i < frcp_pkg::HEAD_DEPTH; i++) r_head[i] <= '0;
        end else if (accept) begin
            if (i_rx.stream_end || line_done) begin
                r_pos <= '0;
                for (int i = 0; i < frcp_pkg::HEAD_DEPTH; i++) r_head[i] <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
                for (int i = 0; i < frcp_pkg::HEAD_DEPTH; i++) r_head[i] <= n_head[i];
            end
        end
    end

endmodule

[hdl/frcp_queue.sv]
// Two-entry queue of line events between the front and the back part.
module frcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  frcp_pkg::t_evt i_evt,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output frcp_pkg::t_evt o_evt
);

    frcp_pkg::t_evt r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_evt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[hdl/frcp_back.sv]
// Back part: applies the reply rules to each line event and drives results.
module frcp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  frcp_pkg::t_evt i_evt,
    output logic           o_pop,
    frcp_out_if.source     o_reply
);

    logic                          r_multi;
    logic [frcp_pkg::CODE_W-1:0]   r_open;
    logic                          r_out_valid;
    logic [frcp_pkg::CODE_W-1:0]   r_code;
    logic                          r_status;
    logic                          ok;
    logic                          done;
    logic                          opens;
    logic                          emit;

    assign o_pop              = i_q_valid && (!r_out_valid || o_reply.ready);
    assign o_reply.valid      = r_out_valid;
    assign o_reply.reply_code = r_code;
    assign o_reply.status     = r_status;

    always_comb begin
        ok    = i_evt.judged && i_evt.digits_ok;
        opens = !r_multi && ok && i_evt.is_dash;
        if (!r_multi) begin
            done = ok && !i_evt.is_dash;
        end else begin
            done = ok && (i_evt.value == r_open) && i_evt.is_space;
        end
        // A stream end always reports, either the completed code or closed.
        emit = i_evt.is_end || done;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_code   <= done ? i_evt.value : '0;
            r_status <= done ? frcp_pkg::STATUS_DONE : frcp_pkg::STATUS_CLOSED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multi     <= 1'b0;
            r_open      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= emit;
                if (emit) begin
                    r_multi <= 1'b0;
                    r_open  <= '0;
                end else if (opens) begin
                    r_multi <= 1'b1;
                    r_open  <= i_evt.value;
                end
            end else if (o_reply.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hdl/ftp_reply_code_parser.sv]
// A result passes from the front through the event queue into the output register of the back part.
// Throughput: one byte per cycle; the front takes a byte whenever the event queue has room.
// The two-entry queue and the output register absorb events while the output stalls; a full queue stops bytes.
// Reset (i_rst_n low, synchronous) clears line position, line head, multiline state,
// the queue and the output valid; no clearing pass is needed.
module ftp_reply_code_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frcp_in_if.sink    i_rx,
    frcp_out_if.source o_reply
);

    logic           q_full;
    logic           q_valid;
    logic           push;
    logic           pop;
    frcp_pkg::t_evt front_evt;
    frcp_pkg::t_evt back_evt;

    frcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_evt    (front_evt)
    );

    frcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (front_evt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_evt   (back_evt)
    );

    frcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_evt     (back_evt),
        .o_pop     (pop),
        .o_reply   (o_reply)
    );

endmodule

[hdl/frcp_checker.sv]
// Port-level checker of the FTP reply-code parser and its bind statement.
`include "ftp_reply_code_parser_assert.svh"

module frcp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [frcp_pkg::CODE_W-1:0] i_reply_code,
    input logic                        i_status
);

    // A closed-stream result carries no code.
    `FRCP_ASSERT_ALWAYS(a_closed_zero, !(i_out_valid && (i_status == frcp_pkg::STATUS_CLOSED)) || (i_reply_code == '0))

    // A completed reply holds a three-digit decimal value.
    `FRCP_ASSERT_ALWAYS(a_code_range, !i_out_valid || (i_reply_code <= 10'd999))

    `FRCP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_reply_code) && $stable(i_status))

endmodule

bind ftp_reply_code_parser frcp_checker u_frcp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_reply.valid),
    .i_out_ready  (o_reply.ready),
    .i_reply_code (o_reply.reply_code),
    .i_status     (o_reply.status)
);

[tb/sv/tb_ftp_reply_code_parser.sv]
// Self-checking testbench of the FTP reply-code parser: a directed table, then random traffic.
module tb_ftp_reply_code_parser;

    localparam int         ITEM_TARGET = 550;
    localparam int         QUIET_TAIL  = 70;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_EVERY = 180;
    localparam int         SETTLE      = 8;
    localparam logic [7:0] CH_CR       = 8'h0D;

    localparam logic DATA  = 1'b0;
    localparam logic CLOSE = 1'b1;
    localparam logic PRED  = 1'b0;
    localparam logic TYPED = 1'b1;

    typedef struct packed {
        logic [7:0]                  rx_byte;
        logic                        stream_end;
        logic                        typed;
        logic [frcp_pkg::CODE_W-1:0] code;
        logic                        status;
    } t_dir_row;

    typedef struct packed {
        logic [frcp_pkg::CODE_W-1:0] code;
        logic                        status;
    } t_reply;

    // Rows marked TYPED carry their reply; the others are predicted.
    localparam t_dir_row DIR_ROWS [0:23] = '{
        {8'h00,              CLOSE, TYPED, 10'd0,   frcp_pkg::STATUS_CLOSED},
        {"0",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"0",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"0",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {8'hFF,              CLOSE, TYPED, 10'd0,   frcp_pkg::STATUS_DONE},
        {"9",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"9",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"9",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {frcp_pkg::CH_DASH,  DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {frcp_pkg::CH_LF,    DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"1",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"2",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {frcp_pkg::CH_LF,    DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"9",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"9",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"9",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {frcp_pkg::CH_SPACE, DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {CH_CR,              DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {frcp_pkg::CH_LF,    DATA,  TYPED, 10'd999, frcp_pkg::STATUS_DONE},
        {"2",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"1",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {"1",                DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {frcp_pkg::CH_DASH,  DATA,  PRED,  10'd0,   frcp_pkg::STATUS_DONE},
        {8'h5A,              CLOSE, TYPED, 10'd0,   frcp_pkg::STATUS_CLOSED}
    };

    logic i_clk;
    logic i_rst_n;

    frcp_in_if  rx_if ();
    frcp_out_if reply_if ();

    ftp_reply_code_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_reply (reply_if)
    );

    // Predictor state.
    int                          ln_count;
    logic [7:0]                  ln_head [0:3];
    logic                        ln_multi;
    logic [frcp_pkg::CODE_W-1:0] ln_open;

    t_reply     pending_replies [$];
    logic [8:0] seq_q [$];

    int errors;
    int cycle_cnt;
    int src_pct;
    int sink_pct;
    int sink_hold;
    int sink_cycles;
    bit quiet;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_digit_char(input logic [7:0] c);
        return (c >= frcp_pkg::CH_ZERO) && (c <= frcp_pkg::CH_NINE);
    endfunction

    function automatic void clear_line();
        ln_count = 0;
        for (int i = 0; i < 4; i++) ln_head[i] = 8'h00;
    endfunction

    // Applies the reply rules to the finished line.
    function automatic logic line_completes(output logic [frcp_pkg::CODE_W-1:0] code);
        int v;
        code = '0;
        if (!(is_digit_char(ln_head[0]) && is_digit_char(ln_head[1]) &&
              is_digit_char(ln_head[2])))
            return 1'b0;
        v = (int'(ln_head[0]) - 48) * 100 + (int'(ln_head[1]) - 48) * 10 +
            (int'(ln_head[2]) - 48);
        if (!ln_multi) begin
            if (ln_head[3] == frcp_pkg::CH_DASH) begin
                ln_multi = 1'b1;
                ln_open  = v[frcp_pkg::CODE_W-1:0];
                return 1'b0;
            end
            code = v[frcp_pkg::CODE_W-1:0];
            return 1'b1;
        end
        if (v[frcp_pkg::CODE_W-1:0] == ln_open && ln_head[3] == frcp_pkg::CH_SPACE) begin
            code     = v[frcp_pkg::CODE_W-1:0];
            ln_multi = 1'b0;
            ln_open  = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic predict_reply(input logic [7:0] b, input logic e,
                                           output logic [frcp_pkg::CODE_W-1:0] code,
                                           output logic st);
        logic done;
        code = '0;
        st   = frcp_pkg::STATUS_DONE;
        done = 1'b0;
        if (e) begin
            // A partial line is judged first; anything short of completion closes.
            if (ln_count > 0) done = line_completes(code);
            if (!done) begin
                code = '0;
                st   = frcp_pkg::STATUS_CLOSED;
            end
            clear_line();
            ln_multi = 1'b0;
            ln_open  = '0;
            return 1'b1;
        end
        if (ln_count < 4) ln_head[ln_count] = b;
        ln_count++;
        if (b == frcp_pkg::CH_LF || ln_count >= frcp_pkg::MAX_LINE - 1) begin
            done = line_completes(code);
            clear_line();
            return done;
        end
        return 1'b0;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    // Mostly printable reply text, never a line feed.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 8) b = 8'($urandom_range(8'h20, 8'h7E));
        else b = 8'($urandom_range(0, 255));
        if (b == frcp_pkg::CH_LF) b = 8'h2E;
        return b;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        seq_q.push_back({1'b0, b});
    endtask

    task automatic add_close();
        seq_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic add_digits(input int v);
        add_byte(frcp_pkg::CH_ZERO + 8'(v / 100));
        add_byte(frcp_pkg::CH_ZERO + 8'((v / 10) % 10));
        add_byte(frcp_pkg::CH_ZERO + 8'(v % 10));
    endtask

    task automatic add_tail(input int n);
        repeat (n) add_byte(text_byte());
        if ($urandom_range(0, 1)) add_byte(CH_CR);
        add_byte(frcp_pkg::CH_LF);
    endtask

    task automatic build_sequence();
        int         kind;
        int         code;
        logic [7:0] head [0:3];
        kind = $urandom_range(0, 99);
        code = $urandom_range(0, 999);
        if (kind < 35) begin
            add_digits(code);
            case ($urandom_range(0, 3))
                0, 1: add_byte(frcp_pkg::CH_SPACE);
                2: ;
                default: add_byte(text_byte());
            endcase
            add_tail($urandom_range(0, 10));
        end else if (kind < 65) begin
            add_digits(code);
            add_byte(frcp_pkg::CH_DASH);
            add_tail($urandom_range(0, 8));
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 5))
                    0: add_tail($urandom_range(0, 10));
                    1: begin
                        add_digits(code);
                        add_byte(frcp_pkg::CH_DASH);
                        add_tail($urandom_range(0, 6));
                    end
                    2: begin
                        add_digits((code + $urandom_range(1, 998)) % 1000);
                        add_byte(frcp_pkg::CH_SPACE);
                        add_tail($urandom_range(0, 6));
                    end
                    3: begin
                        add_digits(code);
                        add_byte(text_byte());
                        add_tail($urandom_range(0, 6));
                    end
                    4: begin
                        add_byte(frcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                        add_byte(frcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                        add_byte(frcp_pkg::CH_LF);
                    end
                    default: begin
                        add_digits(code);
                        add_byte(frcp_pkg::CH_LF);
                    end
                endcase
            end
            // Now and then the connection drops inside the reply.
            if ($urandom_range(0, 9) == 0) begin
                add_close();
            end else begin
                add_digits(code);
                add_byte(frcp_pkg::CH_SPACE);
                add_tail($urandom_range(0, 8));
            end
        end else if (kind < 78) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) add_byte(frcp_pkg::CH_LF);
        end else if (kind < 88) begin
            add_digits(code);
            case ($urandom_range(0, 2))
                0: add_byte(frcp_pkg::CH_DASH);
                1: add_byte(frcp_pkg::CH_SPACE);
                default: ;
            endcase
            add_close();
        end else if (kind < 93) begin
            add_close();
        end else begin
            head[0] = frcp_pkg::CH_ZERO + 8'(code / 100);
            head[1] = frcp_pkg::CH_ZERO + 8'((code / 10) % 10);
            head[2] = frcp_pkg::CH_ZERO + 8'(code % 10);
            head[3] = frcp_pkg::CH_SPACE;
            head[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            for (int i = 0; i < 4; i++) add_byte(head[i]);
            add_tail($urandom_range(0, 6));
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic e, input logic typed,
                             input logic [frcp_pkg::CODE_W-1:0] tcode, input logic tst);
        logic [frcp_pkg::CODE_W-1:0] pcode;
        logic                        pst;
        logic                        got;
        if (!quiet && $urandom_range(0, 99) < src_pct) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        rx_if.valid      <= 1'b1;
        rx_if.rx_byte    <= b;
        rx_if.stream_end <= e;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        got = predict_reply(b, e, pcode, pst);
        if (typed) pending_replies.push_back({tcode, tst});
        else if (got) pending_replies.push_back({pcode, pst});
        @(negedge i_clk);
    endtask

    task automatic drive_sequence(output int n);
        logic [8:0] item;
        n = 0;
        while (seq_q.size() != 0) begin
            item = seq_q.pop_front();
            send_item(item[7:0], item[8], PRED, '0, frcp_pkg::STATUS_DONE);
            n++;
        end
    endtask

    task automatic drain_replies();
        rx_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_replies.size() != 0);
    endtask

    always @(negedge i_clk) begin
        sink_cycles++;
        if (sink_cycles % 64 == 0) sink_pct = pick_pct();
        if (sink_hold > 0) begin
            sink_hold--;
            reply_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < sink_pct) begin
            sink_hold = $urandom_range(0, 8);
            reply_if.ready <= 1'b0;
        end else begin
            reply_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && reply_if.valid && reply_if.ready) begin
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply: expected none, got code %0d status %0d",
                         $time, reply_if.reply_code, reply_if.status);
            end else begin
                want = pending_replies.pop_front();
                if (reply_if.reply_code !== want.code) begin
                    errors++;
                    $display("%0t: reply_code mismatch: expected %0d, got %0d",
                             $time, want.code, reply_if.reply_code);
                end
                if (reply_if.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, reply_if.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int  sent;
        int  n;
        int  next_drain;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = 8'h00;
        rx_if.stream_end = 1'b0;
        reply_if.ready   = 1'b0;
        errors           = 0;
        cycle_cnt        = 0;
        sink_hold        = 0;
        sink_cycles      = 0;
        sink_pct         = 15;
        src_pct          = 20;
        quiet            = 1'b0;
        ln_multi         = 1'b0;
        ln_open          = '0;
        clear_line();
        sent             = 0;
        next_drain       = DRAIN_EVERY;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i])
            send_item(DIR_ROWS[i].rx_byte, DIR_ROWS[i].stream_end, DIR_ROWS[i].typed,
                      DIR_ROWS[i].code, DIR_ROWS[i].status);
        drain_replies();

        while (sent < ITEM_TARGET) begin
            src_pct = pick_pct();
            quiet   = (sent > ITEM_TARGET - QUIET_TAIL);
            if (sent >= next_drain) begin
                drain_replies();
                next_drain += DRAIN_EVERY;
            end
            build_sequence();
            drive_sequence(n);
            sent += n;
        end

        rx_if.valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
